### rtl/core/aste_pkg.sv
// Package: register indexes, reset values and shared constants of the tempo estimator.
package aste_pkg;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FAST_GAIN      = 3'd0,
        REG_SLOW_GAIN      = 3'd1,
        REG_ACTIVITY_GAIN  = 3'd2,
        REG_ACT_THRESHOLD  = 3'd3,
        REG_CROSS_TOL      = 3'd4,
        REG_BPM_PER_CROSS  = 3'd5
    } cfg_index_t;

    localparam logic [15:0] FAST_GAIN_RST = 16'd19661;
    localparam logic [15:0] SLOW_GAIN_RST = 16'd3277;
    localparam logic [15:0] ACT_GAIN_RST  = 16'd1966;
    localparam logic [11:0] ACT_THR_RST   = 12'd15;
    localparam logic [11:0] CROSS_TOL_RST = 12'd2;
    localparam logic [7:0]  BPM_PER_RST   = 8'd5;

    localparam logic [15:0] PERIOD_NUM = 16'd60000;
endpackage

### rtl/core/aste_ram.sv
// Generic single-port RAM with registered read.
module aste_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### rtl/core/accel_shake_tempo_estimator.sv
// Top level of the accelerometer shake tempo estimator.
//
// Input channel s_*: one 3-axis sample per item (valid/ready). Result channel
// m_*: one item per sample, with crossing flag, tempo in bpm, activity and
// beat period in ms. Configuration: write cfg_we with cfg_index/cfg_data,
// only while the block is idle.
//
// Processing steps in order: squares, square root (one result bit a
// cycle), three IIR filters of 2 multiplies each through one shared 17x16
// multiplier, high-pass, window update (registered RAM read), tempo
// multiply, period divide (one quotient bit a cycle), output. When
// activity is not above the threshold the window write is skipped. Only
// one sample is in work; s_ready is high in the idle state, so a new item
// is taken only once the result of the last one has been loaded into the
// output register.
// The result waits in an output register; while m_ready is low the next
// sample is still accepted and worked on, and it stalls only at its own
// result until the register is free.
//
// After reset the window RAM is cleared, one entry a cycle, over all
// WINDOW_LEN entries, during which no sample is accepted.
module accel_shake_tempo_estimator #(
    parameter int WINDOW_LEN  = 750,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [aste_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aste_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [SAMPLE_BITS-1:0]   s_accel_x,
    input  logic signed [SAMPLE_BITS-1:0]   s_accel_y,
    input  logic signed [SAMPLE_BITS-1:0]   s_accel_z,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_crossing_seen,
    output logic [15:0]                     m_tempo_bpm,
    output logic [11:0]                     m_activity_level,
    output logic [15:0]                     m_beat_period_ms
);
    import aste_pkg::*;

    localparam int PW = $clog2(WINDOW_LEN);
    localparam int NW = $clog2(WINDOW_LEN + 1);   // ones in the window
    localparam int SQW = 2 * SAMPLE_BITS + 2;   // sum of three squares
    localparam int RW = SAMPLE_BITS + 1;        // root width
    localparam int RSTEPS = (SQW + 1) / 2;
    localparam int CW = $clog2(RSTEPS + 1) + 5;
    localparam logic [PW-1:0] PTR_LAST = PW'(WINDOW_LEN - 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SQ, ST_ROOT, ST_IIR, ST_HP, ST_WIN_RD, ST_WIN_WR,
        ST_BPM, ST_DIV, ST_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0] fast_gain_reg, slow_gain_reg, act_gain_reg;
    logic [11:0] act_thr_reg, cross_tol_reg;
    logic [7:0]  bpm_per_reg;

    // filter state
    logic [15:0] fast_reg, slow_reg, act_reg;
    logic signed [15:0] prev_hp_reg;
    logic [PW-1:0] ptr_reg;
    logic [NW-1:0] count_reg;

    // work registers
    logic signed [SAMPLE_BITS-1:0] ax_reg, ay_reg, az_reg;
    logic [SQW-1:0] sq_reg;
    logic [RW-1:0]  root_reg;
    logic [SQW-1:0] rem_reg;
    logic [CW-1:0]  cnt_reg;
    logic [32:0]    acc_reg;
    logic [15:0]    mag_reg;
    logic signed [15:0] hp_reg;
    logic           crossed_reg;
    logic [15:0]    bpm_reg;
    logic [16:0]    drem_reg;
    logic [15:0]    quot_reg;

    // shared multiplier: 17 x 16 unsigned
    logic [16:0] mul_a;
    logic [15:0] mul_b;
    logic [32:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // multiplier operand selection for squares, IIR steps and the tempo multiply
    logic [15:0] prev_abs;
    assign prev_abs = prev_hp_reg[15] ? 16'(-prev_hp_reg) : prev_hp_reg;

    always_comb begin
        logic signed [SAMPLE_BITS-1:0] s;
        logic [SAMPLE_BITS-1:0] sabs;
        logic [15:0] g, y, x;
        mul_a = '0;
        mul_b = '0;
        s = '0;
        sabs = '0;
        g = '0;
        y = '0;
        x = '0;
        case (state_reg)
            ST_SQ: begin
                case (cnt_reg[1:0])
                    2'd0:    s = ax_reg;
                    2'd1:    s = ay_reg;
                    default: s = az_reg;
                endcase
                // magnitude as unsigned, so the most negative sample stays positive
                sabs = s[SAMPLE_BITS-1] ? -s : s;
                mul_a = 17'(sabs);
                mul_b = 16'(sabs);
            end
            ST_IIR: begin
                case (cnt_reg[2:1])
                    2'd0: begin g = fast_gain_reg; y = fast_reg; x = mag_reg; end
                    2'd1: begin g = act_gain_reg;  y = act_reg;  x = prev_abs; end
                    default: begin g = slow_gain_reg; y = slow_reg; x = mag_reg; end
                endcase
                if (!cnt_reg[0]) begin
                    mul_a = 17'h10000 - {1'b0, g};
                    mul_b = y;
                end else begin
                    mul_a = {1'b0, g};
                    mul_b = x;
                end
            end
            ST_BPM: begin
                mul_a = 17'(count_reg);
                mul_b = {8'd0, bpm_per_reg};
            end
            default: ;
        endcase
    end

    // window RAM
    logic          ram_we;
    logic [PW-1:0] ram_addr;
    logic          ram_wdata, ram_rdata;

    aste_ram #(.WIDTH(1), .DEPTH(WINDOW_LEN)) u_window (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    always_comb begin
        ram_we = 1'b0;
        ram_wdata = 1'b0;
        ram_addr = ptr_reg;
        if (state_reg == ST_CLEAR) begin
            ram_we = 1'b1;
        end else if (state_reg == ST_WIN_WR) begin
            ram_we = 1'b1;
            ram_wdata = crossed_reg;
        end
    end

    // square-root step
    logic [SQW-1:0] trial;
    logic [1:0]     pair;
    logic [SQW-1:0] rem_sh;
    always_comb begin
        pair = sq_reg[SQW-1 -: 2];
        rem_sh = {rem_reg[SQW-3:0], pair};
        trial = SQW'({root_reg, 2'b01});
    end

    // high-pass
    logic signed [17:0] hp_wide;
    logic signed [17:0] rise;
    assign hp_wide = $signed({2'b00, fast_reg}) - $signed({2'b00, slow_reg});
    assign rise = 18'(hp_reg) - 18'(prev_hp_reg);

    // divider step
    logic [16:0] dtrial;
    assign dtrial = {drem_reg[15:0], PERIOD_NUM[15 - cnt_reg[3:0]]};

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            fast_gain_reg <= FAST_GAIN_RST;
            slow_gain_reg <= SLOW_GAIN_RST;
            act_gain_reg <= ACT_GAIN_RST;
            act_thr_reg <= ACT_THR_RST;
            cross_tol_reg <= CROSS_TOL_RST;
            bpm_per_reg <= BPM_PER_RST;
            fast_reg <= '0;
            slow_reg <= '0;
            act_reg <= '0;
            prev_hp_reg <= '0;
            ptr_reg <= '0;
            count_reg <= '0;
            cnt_reg <= '0;
            m_valid <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_FAST_GAIN:     fast_gain_reg <= cfg_data;
                    REG_SLOW_GAIN:     slow_gain_reg <= cfg_data;
                    REG_ACTIVITY_GAIN: act_gain_reg <= cfg_data;
                    REG_ACT_THRESHOLD: act_thr_reg <= cfg_data[11:0];
                    REG_CROSS_TOL:     cross_tol_reg <= cfg_data[11:0];
                    REG_BPM_PER_CROSS: bpm_per_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready && state_reg != ST_OUT) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    if (ptr_reg == PTR_LAST) begin
                        ptr_reg <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        ax_reg <= s_accel_x;
                        ay_reg <= s_accel_y;
                        az_reg <= s_accel_z;
                        sq_reg <= '0;
                        cnt_reg <= '0;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    sq_reg <= sq_reg + SQW'(mul_p);
                    if (cnt_reg == CW'(2)) begin
                        cnt_reg <= '0;
                        root_reg <= '0;
                        rem_reg <= '0;
                        state_reg <= ST_ROOT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_ROOT: begin
                    // one root bit a cycle, two radicand bits consumed
                    sq_reg <= {sq_reg[SQW-3:0], 2'b00};
                    if (rem_sh >= trial) begin
                        rem_reg <= rem_sh - trial;
                        root_reg <= {root_reg[RW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        root_reg <= {root_reg[RW-2:0], 1'b0};
                    end
                    if (cnt_reg == CW'(RSTEPS - 1)) begin
                        cnt_reg <= '0;
                        state_reg <= ST_IIR;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_IIR: begin
                    if (cnt_reg == '0) begin
                        mag_reg <= 16'(root_reg);
                    end
                    if (!cnt_reg[0]) begin
                        acc_reg <= mul_p;
                    end else begin
                        case (cnt_reg[2:1])
                            2'd0:    fast_reg <= 16'((acc_reg + mul_p) >> 16);
                            2'd1:    act_reg <= 16'((acc_reg + mul_p) >> 16);
                            default: slow_reg <= 16'((acc_reg + mul_p) >> 16);
                        endcase
                    end
                    if (cnt_reg == CW'(5)) begin
                        cnt_reg <= '0;
                        state_reg <= ST_HP;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_HP: begin
                    // saturate fast minus slow
                    if (hp_wide > 18'sd32767) begin
                        hp_reg <= 16'sh7fff;
                    end else if (hp_wide < -18'sd32768) begin
                        hp_reg <= 16'sh8000;
                    end else begin
                        hp_reg <= 16'(hp_wide);
                    end
                    state_reg <= ST_WIN_RD;
                end
                ST_WIN_RD: begin
                    if ({4'd0, act_reg} > {8'd0, act_thr_reg}) begin
                        crossed_reg <= (hp_reg > 0) && prev_hp_reg[15]
                                       && (rise > $signed({6'd0, cross_tol_reg}));
                        state_reg <= ST_WIN_WR;
                    end else begin
                        crossed_reg <= 1'b0;
                        state_reg <= ST_BPM;
                    end
                end
                ST_WIN_WR: begin
                    count_reg <= count_reg - NW'(ram_rdata) + NW'(crossed_reg);
                    ptr_reg <= (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
                    state_reg <= ST_BPM;
                end
                ST_BPM: begin
                    prev_hp_reg <= hp_reg;
                    bpm_reg <= (mul_p > 33'd65535) ? 16'hffff : mul_p[15:0];
                    drem_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (dtrial >= {1'b0, bpm_reg}) begin
                        drem_reg <= dtrial - {1'b0, bpm_reg};
                        quot_reg <= {quot_reg[14:0], 1'b1};
                    end else begin
                        drem_reg <= dtrial;
                        quot_reg <= {quot_reg[14:0], 1'b0};
                    end
                    if (cnt_reg == CW'(15)) begin
                        cnt_reg <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (!m_valid || m_ready) begin
                        m_valid <= 1'b1;
                        m_crossing_seen <= crossed_reg;
                        m_tempo_bpm <= bpm_reg;
                        m_activity_level <= (act_reg > 16'd4095) ? 12'hfff : act_reg[11:0];
                        m_beat_period_ms <= (bpm_reg == '0) ? PERIOD_NUM : quot_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

### test/tb.sv
// Testbench of the shake tempo estimator: directed and random samples against a predictor.
module tb;
    import aste_pkg::*;

    localparam int WIN = 750;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic signed [11:0] s_accel_x = '0, s_accel_y = '0, s_accel_z = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_crossing_seen;
    logic [15:0] m_tempo_bpm;
    logic [11:0] m_activity_level;
    logic [15:0] m_beat_period_ms;

    accel_shake_tempo_estimator u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_accel_x(s_accel_x), .s_accel_y(s_accel_y), .s_accel_z(s_accel_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_crossing_seen(m_crossing_seen), .m_tempo_bpm(m_tempo_bpm),
        .m_activity_level(m_activity_level), .m_beat_period_ms(m_beat_period_ms)
    );

    typedef struct packed {
        logic        crossing;
        logic [15:0] bpm;
        logic [11:0] act;
        logic [15:0] period;
    } tempo_t;

    tempo_t tempo_q[$];
    int     fails = 0;
    bit     stall_on = 1'b1;

    // predictor state and registers
    logic [15:0] p_fast_gain, p_slow_gain, p_act_gain;
    logic [11:0] p_thr, p_tol;
    logic [7:0]  p_bpm_per;
    int unsigned p_fast, p_slow, p_act, p_ptr, p_count;
    int          p_prev_hp;
    bit          p_window[WIN];

    initial forever #5 aclk = ~aclk;

    function automatic int unsigned root_floor(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int unsigned smooth(int unsigned g, int unsigned x, int unsigned y);
        longint unsigned acc;
        acc = longint'(65536 - g) * y + longint'(g) * x;
        return int'(acc >> 16);
    endfunction

    task automatic predictor_reset();
        p_fast_gain = FAST_GAIN_RST;
        p_slow_gain = SLOW_GAIN_RST;
        p_act_gain  = ACT_GAIN_RST;
        p_thr = ACT_THR_RST;
        p_tol = CROSS_TOL_RST;
        p_bpm_per = BPM_PER_RST;
        p_fast = 0; p_slow = 0; p_act = 0; p_prev_hp = 0; p_ptr = 0; p_count = 0;
        foreach (p_window[i]) p_window[i] = 1'b0;
    endtask

    function automatic tempo_t predict_tempo(logic signed [11:0] x, logic signed [11:0] y,
                                             logic signed [11:0] z);
        tempo_t r;
        longint sq;
        int unsigned mag, bpm;
        int hp;
        bit crossed;
        sq = longint'(x) * x + longint'(y) * y + longint'(z) * z;
        mag = root_floor(sq);
        crossed = 1'b0;
        p_fast = smooth(p_fast_gain, mag, p_fast);
        p_act  = smooth(p_act_gain, (p_prev_hp < 0) ? -p_prev_hp : p_prev_hp, p_act);
        p_slow = smooth(p_slow_gain, mag, p_slow);
        hp = int'(p_fast) - int'(p_slow);
        if (hp > 32767) hp = 32767;
        if (hp < -32768) hp = -32768;
        if (p_act > p_thr) begin
            if (hp > 0 && p_prev_hp < 0 && (hp - p_prev_hp) > int'(p_tol)) crossed = 1'b1;
            if (p_ptr >= WIN) p_ptr = 0;
            p_count = p_count - p_window[p_ptr] + crossed;
            p_window[p_ptr] = crossed;
            p_ptr++;
            if (p_ptr >= WIN) p_ptr = 0;
        end
        p_prev_hp = hp;
        bpm = p_bpm_per * p_count;
        if (bpm > 65535) bpm = 65535;
        r.crossing = crossed;
        r.bpm = bpm[15:0];
        r.act = (p_act > 4095) ? 12'd4095 : p_act[11:0];
        r.period = (bpm > 0) ? 16'(60000 / bpm) : PERIOD_NUM;
        return r;
    endfunction

    task automatic send_sample(logic signed [11:0] x, logic signed [11:0] y,
                               logic signed [11:0] z);
        s_valid <= 1'b1;
        s_accel_x <= x;
        s_accel_y <= y;
        s_accel_z <= z;
        do @(posedge aclk); while (!s_ready);
        tempo_q.push_back(predict_tempo(x, y, z));
        // random gap after the item, often none
        if ($urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (tempo_q.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FAST_GAIN:     p_fast_gain = val;
            REG_SLOW_GAIN:     p_slow_gain = val;
            REG_ACTIVITY_GAIN: p_act_gain = val;
            REG_ACT_THRESHOLD: p_thr = val[11:0];
            REG_CROSS_TOL:     p_tol = val[11:0];
            REG_BPM_PER_CROSS: p_bpm_per = val[7:0];
            default: ;
        endcase
    endtask

    // shaking: magnitude swings between two levels with random jitter
    task automatic shake_run(int n, int half);
        int lvl;
        for (int i = 0; i < n; i++) begin
            lvl = ((i / half) % 2) ? $urandom_range(1500, 2047) : $urandom_range(0, 300);
            send_sample(12'(lvl), 12'($urandom_range(0, 60)) - 12'sd30,
                        12'($urandom_range(0, 60)) - 12'sd30);
        end
    endtask

    task automatic test_extremes();
        logic signed [11:0] v[4] = '{-12'sd2048, 12'sd2047, 12'sd0, -12'sd1};
        foreach (v[i]) send_sample(v[i], v[(i + 1) % 4], v[(i + 2) % 4]);
        send_sample(-12'sd2048, -12'sd2048, -12'sd2048);
        send_sample(12'sd2047, 12'sd2047, 12'sd2047);
        // hold a constant level so the high-pass decays toward zero
        for (int i = 0; i < 8; i++) send_sample(12'sd100, 12'sd0, 12'sd0);
        shake_run(10, 2);
        wait_drained();
    endtask

    task automatic test_defaults_shake();
        shake_run(150, 3);
        wait_drained();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_FAST_GAIN, 16'hFFFF);
        write_reg(REG_SLOW_GAIN, 16'h0000);
        write_reg(REG_ACTIVITY_GAIN, 16'hFFFF);
        write_reg(REG_ACT_THRESHOLD, 16'h0000);
        write_reg(REG_CROSS_TOL, 16'h0000);
        write_reg(REG_BPM_PER_CROSS, 16'h00FF);
        shake_run(150, 1);
        wait_drained();
        // large threshold and tolerance: window frozen
        write_reg(REG_ACT_THRESHOLD, 16'hFFFF);
        write_reg(REG_CROSS_TOL, 16'hFFFF);
        write_reg(REG_BPM_PER_CROSS, 16'h0000);
        shake_run(40, 2);
        wait_drained();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(REG_FAST_GAIN, 16'($urandom_range(3000, 65535)));
            write_reg(REG_SLOW_GAIN, 16'($urandom_range(0, 8000)));
            write_reg(REG_ACTIVITY_GAIN, 16'($urandom()));
            write_reg(REG_ACT_THRESHOLD, 16'($urandom_range(0, 60)));
            write_reg(REG_CROSS_TOL, 16'($urandom_range(0, 20)));
            write_reg(REG_BPM_PER_CROSS, 16'($urandom_range(0, 255)));
            stall_on = (ph != 1);
            shake_run(60, $urandom_range(1, 4));
            for (int i = 0; i < 20; i++)
                send_sample(12'($urandom()), 12'($urandom()), 12'($urandom()));
            wait_drained();
        end
        stall_on = 1'b1;
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!stall_on) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 99) < 70);
    end

    always @(posedge aclk) begin
        tempo_t got, exp_r;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_crossing_seen, m_tempo_bpm, m_activity_level, m_beat_period_ms};
            if (tempo_q.size() == 0) begin
                $error("unexpected result item");
                fails++;
            end else begin
                exp_r = tempo_q.pop_front();
                if (got.crossing !== exp_r.crossing) begin
                    $error("crossing_seen exp %0d got %0d", exp_r.crossing, got.crossing);
                    fails++;
                end
                if (got.bpm !== exp_r.bpm) begin
                    $error("tempo_bpm exp %0d got %0d", exp_r.bpm, got.bpm);
                    fails++;
                end
                if (got.act !== exp_r.act) begin
                    $error("activity_level exp %0d got %0d", exp_r.act, got.act);
                    fails++;
                end
                if (got.period !== exp_r.period) begin
                    $error("beat_period_ms exp %0d got %0d", exp_r.period, got.period);
                    fails++;
                end
            end
        end
    end

    initial begin
        predictor_reset();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_extremes();
        test_defaults_shake();
        test_register_extremes();
        test_random();
        if (fails == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
